FILE: src/memory_bank_length_prober_core_defines.svh
// Assertion macros for the memory bank length prober.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MEMORY_BANK_LENGTH_PROBER_CORE_DEFINES_SVH
`define MEMORY_BANK_LENGTH_PROBER_CORE_DEFINES_SVH

// same-cycle implication
`define MBLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mblp_pkg.sv
// Shared types and codes for the memory bank length prober.
// No dependencies; used by every module of the block.
package mblp_pkg;

    localparam logic [1:0] ACT_START    = 2'd0;
    localparam logic [1:0] ACT_RESPONSE = 2'd1;
    localparam logic [1:0] ACT_STOP     = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERRUN   = 3'd1;
    localparam logic [2:0] ST_WRONG_PW  = 3'd2;
    localparam logic [2:0] ST_LOCKED    = 3'd3;

    localparam logic KIND_PROBE  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [1:0] OUT_SUCCESS = 2'd0;
    localparam logic [1:0] OUT_FAILED  = 2'd1;
    localparam logic [1:0] OUT_ABORTED = 2'd2;

    localparam logic REG_MAX_WORDS   = 1'b0;
    localparam logic REG_MAX_RETRIES = 1'b1;

    localparam logic [7:0] MAX_WORDS_RESET   = 8'd64;
    localparam logic [7:0] MAX_RETRIES_RESET = 8'd10;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic       busy;
        logic [8:0] range_low;
        logic [8:0] range_high;
        logic [7:0] current_probe;
        logic [7:0] retry_count;
        logic [1:0] active_bank;
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] probe_bank;
        logic [7:0] probe_words;
        logic [7:0] attempt_index;
        logic [1:0] outcome;
        logic [7:0] bank_words;
    } result_t;

endpackage

FILE: src/mblp_cfg.sv
// Configuration registers (max_words, max_retries) behind an APB-style port.
// Depends on mblp_pkg.
module mblp_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mblp_pkg::ADDR_W-1:0]  paddr,
    input  logic [mblp_pkg::DATA_W-1:0]  pwdata,
    output logic [mblp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [7:0]                   max_words,
    output logic [7:0]                   max_retries
);

    logic [7:0] max_words_reg;
    logic [7:0] max_retries_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_words_reg   <= mblp_pkg::MAX_WORDS_RESET;
            max_retries_reg <= mblp_pkg::MAX_RETRIES_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == mblp_pkg::REG_MAX_WORDS)
                max_words_reg <= pwdata[7:0];
            else
                max_retries_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == mblp_pkg::REG_MAX_WORDS)
            prdata = {{(mblp_pkg::DATA_W-8){1'b0}}, max_words_reg};
        else
            prdata = {{(mblp_pkg::DATA_W-8){1'b0}}, max_retries_reg};
    end

    assign max_words   = max_words_reg;
    assign max_retries = max_retries_reg;

endmodule

FILE: src/mblp_step.sv
// Search step logic: next search state and optional result for one transaction.
// Depends on mblp_pkg.
module mblp_step (
    input  mblp_pkg::state_t  st,
    input  logic [1:0]        action,
    input  logic [1:0]        bank_select,
    input  logic [2:0]        reply_status,
    input  logic [7:0]        max_words,
    input  logic [7:0]        max_retries,
    output mblp_pkg::state_t  st_next,
    output logic              has_result,
    output mblp_pkg::result_t res
);

    logic       do_adv;
    logic       do_fin;
    logic [1:0] fin_outcome;
    logic [7:0] fin_words;
    logic [8:0] a_low;
    logic [8:0] a_high;
    logic [9:0] sum;
    logic [7:0] mid;
    logic [7:0] retry_inc;

    always_comb
    begin
        st_next     = st;
        do_adv      = 1'b0;
        do_fin      = 1'b0;
        fin_outcome = mblp_pkg::OUT_SUCCESS;
        fin_words   = 8'd0;
        has_result  = 1'b0;
        res         = '0;
        a_low       = st.range_low;
        a_high      = st.range_high;
        retry_inc   = st.retry_count + 8'd1;

        case (action)
            mblp_pkg::ACT_START:
            begin
                st_next.active_bank = bank_select;
                a_low  = 9'd0;
                a_high = {1'b0, max_words};
                do_adv = 1'b1;
            end
            mblp_pkg::ACT_STOP:
            begin
                if (st.busy)
                begin
                    do_fin      = 1'b1;
                    fin_outcome = mblp_pkg::OUT_ABORTED;
                end
            end
            mblp_pkg::ACT_RESPONSE:
            begin
                if (st.busy)
                begin
                    if (reply_status == mblp_pkg::ST_OK)
                    begin
                        a_low  = {1'b0, st.current_probe} + 9'd1;
                        do_adv = 1'b1;
                    end
                    else if (reply_status == mblp_pkg::ST_OVERRUN)
                    begin
                        a_high = {1'b0, st.current_probe} - 9'd1;
                        do_adv = 1'b1;
                    end
                    else if (reply_status inside {mblp_pkg::ST_WRONG_PW, mblp_pkg::ST_LOCKED})
                    begin
                        do_fin      = 1'b1;
                        fin_outcome = mblp_pkg::OUT_FAILED;
                    end
                    else
                    begin
                        // transient, and unknown codes treated alike
                        st_next.retry_count = retry_inc;
                        if (retry_inc >= max_retries)
                        begin
                            do_fin      = 1'b1;
                            fin_outcome = mblp_pkg::OUT_FAILED;
                        end
                        else
                        begin
                            has_result        = 1'b1;
                            res.kind          = mblp_pkg::KIND_PROBE;
                            res.probe_bank    = st.active_bank;
                            res.probe_words   = st.current_probe;
                            res.attempt_index = retry_inc;
                        end
                    end
                end
            end
            default:
            begin
                // unused action code: no effect
            end
        endcase

        sum = {1'b0, a_low} + {1'b0, a_high};
        mid = sum[8:1];

        if (do_adv)
        begin
            st_next.range_low  = a_low;
            st_next.range_high = a_high;
            if (a_low > a_high)
            begin
                do_fin    = 1'b1;
                fin_words = 8'(a_low - 9'd1);
            end
            else if (mid == 8'd0)
            begin
                do_fin = 1'b1;
            end
            else
            begin
                st_next.current_probe = mid;
                st_next.retry_count   = 8'd0;
                st_next.busy          = 1'b1;
                has_result            = 1'b1;
                res.kind              = mblp_pkg::KIND_PROBE;
                res.probe_bank        = st_next.active_bank;
                res.probe_words       = mid;
                res.attempt_index     = 8'd0;
            end
        end

        if (do_fin)
        begin
            st_next.busy   = 1'b0;
            has_result     = 1'b1;
            res            = '0;
            res.kind       = mblp_pkg::KIND_FINISH;
            res.probe_bank = st_next.active_bank;
            res.outcome    = fin_outcome;
            res.bank_words = fin_words;
        end
    end

endmodule

FILE: src/memory_bank_length_prober_core.sv
// Top level of the memory bank length prober. Depends on mblp_pkg, mblp_cfg,
// mblp_step and the assertion macro header.
// An accepted transaction is held in the input register; the combinational step logic
// sits between the input register and the result register that holds its result.
// Throughput: one transaction per cycle; a stalled result holds the input register.
// Reset (rst_n, async, active low) clears search state and valid flags, loads 64 / 10.
`include "memory_bank_length_prober_core_defines.svh"

module memory_bank_length_prober_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [1:0]                   bank_select,
    input  logic [2:0]                   reply_status,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [1:0]                   probe_bank,
    output logic [7:0]                   probe_words,
    output logic [7:0]                   attempt_index,
    output logic [1:0]                   outcome,
    output logic [7:0]                   bank_words,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mblp_pkg::ADDR_W-1:0]  paddr,
    input  logic [mblp_pkg::DATA_W-1:0]  pwdata,
    output logic [mblp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    logic [7:0] max_words;
    logic [7:0] max_retries;

    logic       in_valid_reg;
    logic [1:0] action_reg;
    logic [1:0] bank_reg;
    logic [2:0] status_reg;

    mblp_pkg::state_t  st_reg;
    mblp_pkg::state_t  st_next;
    mblp_pkg::result_t res;
    mblp_pkg::result_t res_reg;
    logic              has_result;
    logic              out_valid_reg;
    logic              out_free;
    logic              proc;
    logic              in_take;

    mblp_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_words   (max_words),
        .max_retries (max_retries)
    );

    mblp_step u_step (
        .st           (st_reg),
        .action       (action_reg),
        .bank_select  (bank_reg),
        .reply_status (status_reg),
        .max_words    (max_words),
        .max_retries  (max_retries),
        .st_next      (st_next),
        .has_result   (has_result),
        .res          (res)
    );

    // a transaction with no result never waits on the output side
    assign out_free = !out_valid_reg || !out_stall;
    assign proc     = in_valid_reg && (!has_result || out_free);
    assign in_stall = in_valid_reg && !proc;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;

            if (proc)
                st_reg <= st_next;

            if (proc && has_result)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            bank_reg   <= bank_select;
            status_reg <= reply_status;
        end
        if (proc && has_result)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = res_reg.kind;
    assign probe_bank    = res_reg.probe_bank;
    assign probe_words   = res_reg.probe_words;
    assign attempt_index = res_reg.attempt_index;
    assign outcome       = res_reg.outcome;
    assign bank_words    = res_reg.bank_words;

    `MBLP_ASSERT_NOW(a_busy_probe_nonzero, st_reg.busy,
        (st_reg.current_probe != 8'd0) && (st_reg.range_high[8] == 1'b0),
        "busy search with zero probe or out-of-range upper bound")

    `MBLP_ASSERT_NEXT(a_probe_sets_busy,
        proc && has_result && (res.kind == mblp_pkg::KIND_PROBE),
        st_reg.busy, "probe issued but search not busy")

    `MBLP_ASSERT_NOW(a_finish_fields, out_valid_reg && (res_reg.kind == mblp_pkg::KIND_FINISH),
        (res_reg.probe_words == 8'd0) && (res_reg.attempt_index == 8'd0),
        "finish transaction carries probe fields")

    `MBLP_ASSERT_NOW(a_no_lost_result, out_valid_reg && out_stall,
        !(proc && has_result), "result register overwritten while stalled")

endmodule

FILE: tb/sv/tb_memory_bank_length_prober_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for memory_bank_length_prober_core.
// Depends on mblp_pkg and the RTL; holds its own binary-search predictor and scoreboard.

module tb_memory_bank_length_prober_core;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [2:0] ST_TRANSIENT = 3'd4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int TOTAL_ITEMS  = 1850;
    localparam int NUM_PHASES   = 9;

    class probe_scoreboard;
        logic [7:0]        word_limit;
        logic [7:0]        retry_limit;
        logic              searching;
        logic [8:0]        lo_bound;
        logic [8:0]        hi_bound;
        logic [7:0]        probe_len;
        logic [7:0]        retries_used;
        logic [1:0]        bank;
        mblp_pkg::result_t expected_steps[$];
        int                errors;

        function new();
            word_limit   = mblp_pkg::MAX_WORDS_RESET;
            retry_limit  = mblp_pkg::MAX_RETRIES_RESET;
            searching    = 1'b0;
            lo_bound     = '0;
            hi_bound     = '0;
            probe_len    = '0;
            retries_used = '0;
            bank         = '0;
            errors       = 0;
        endfunction

        function void set_register(logic reg_idx, logic [7:0] value);
            if (reg_idx == mblp_pkg::REG_MAX_WORDS)
                word_limit = value;
            else
                retry_limit = value;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        function void push_finish(logic [1:0] result, logic [7:0] words);
            mblp_pkg::result_t r;
            searching       = 1'b0;
            r.kind          = mblp_pkg::KIND_FINISH;
            r.probe_bank    = bank;
            r.probe_words   = '0;
            r.attempt_index = '0;
            r.outcome       = result;
            r.bank_words    = words;
            expected_steps.push_back(r);
        endfunction

        function void push_probe();
            mblp_pkg::result_t r;
            r.kind          = mblp_pkg::KIND_PROBE;
            r.probe_bank    = bank;
            r.probe_words   = probe_len;
            r.attempt_index = retries_used;
            r.outcome       = mblp_pkg::OUT_SUCCESS;
            r.bank_words    = '0;
            expected_steps.push_back(r);
        endfunction

        // next midpoint, or finish when the bounds cross or the midpoint hits zero
        function void advance_search();
            logic [9:0] span;
            logic [8:0] below;
            span  = {1'b0, lo_bound} + {1'b0, hi_bound};
            below = lo_bound - 9'd1;
            if (lo_bound > hi_bound)
                push_finish(mblp_pkg::OUT_SUCCESS, below[7:0]);
            else if (span[8:1] == 8'd0)
                push_finish(mblp_pkg::OUT_SUCCESS, 8'd0);
            else
            begin
                probe_len    = span[8:1];
                retries_used = '0;
                searching    = 1'b1;
                push_probe();
            end
        endfunction

        function void note_request(logic [1:0] act, logic [1:0] sel, logic [2:0] status);
            if (act == mblp_pkg::ACT_START)
            begin
                bank     = sel;
                lo_bound = '0;
                hi_bound = {1'b0, word_limit};
                advance_search();
            end
            else if (act == mblp_pkg::ACT_STOP)
            begin
                if (searching)
                    push_finish(mblp_pkg::OUT_ABORTED, 8'd0);
            end
            else if (act == mblp_pkg::ACT_RESPONSE && searching)
            begin
                if (status == mblp_pkg::ST_OK)
                begin
                    lo_bound = {1'b0, probe_len} + 9'd1;
                    advance_search();
                end
                else if (status == mblp_pkg::ST_OVERRUN)
                begin
                    hi_bound = {1'b0, probe_len} - 9'd1;
                    advance_search();
                end
                else if (status == mblp_pkg::ST_WRONG_PW || status == mblp_pkg::ST_LOCKED)
                    push_finish(mblp_pkg::OUT_FAILED, 8'd0);
                else
                begin
                    // codes above locked all count as transient
                    retries_used = retries_used + 8'd1;
                    if (retries_used >= retry_limit)
                        push_finish(mblp_pkg::OUT_FAILED, 8'd0);
                    else
                        push_probe();
                end
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(mblp_pkg::result_t got);
            mblp_pkg::result_t want;
            if (expected_steps.size() == 0)
            begin
                report_mismatch("result transaction with nothing expected");
                return;
            end
            want = expected_steps.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("probe_bank", got.probe_bank, want.probe_bank);
            compare_field("probe_words", got.probe_words, want.probe_words);
            compare_field("attempt_index", got.attempt_index, want.attempt_index);
            compare_field("outcome", got.outcome, want.outcome);
            compare_field("bank_words", got.bank_words, want.bank_words);
        endtask
    endclass

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [1:0]                    action       = '0;
    logic [1:0]                    bank_select  = '0;
    logic [2:0]                    reply_status = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic                          kind;
    logic [1:0]                    probe_bank;
    logic [7:0]                    probe_words;
    logic [7:0]                    attempt_index;
    logic [1:0]                    outcome;
    logic [7:0]                    bank_words;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [mblp_pkg::ADDR_W-1:0]   paddr        = '0;
    logic [mblp_pkg::DATA_W-1:0]   pwdata       = '0;
    logic [mblp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    probe_scoreboard sb;
    int  cycles       = 0;
    int  sent         = 0;
    bit  input_gaps   = 1'b1;
    bit  stall_bursts = 1'b1;
    bit  calm         = 1'b0;

    memory_bank_length_prober_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .bank_select   (bank_select),
        .reply_status  (reply_status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .probe_bank    (probe_bank),
        .probe_words   (probe_words),
        .attempt_index (attempt_index),
        .outcome       (outcome),
        .bank_words    (bank_words),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // values seen here are the ones in place before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({kind, probe_bank, probe_words, attempt_index, outcome, bank_words});
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_bursts && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [1:0] sel,
                             input logic [2:0] status);
        if (input_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        bank_select  <= sel;
        reply_status <= status;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(act, sel, status);
        sent++;
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  3'($urandom_range(0, 7)));
    endtask

    // stop driving and let every pending result (and any silent transaction) drain
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic reg_idx, input logic [7:0] value);
        logic [mblp_pkg::DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {{(mblp_pkg::DATA_W-8){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_register(reg_idx, value);
        // read back the same register
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback != {{(mblp_pkg::DATA_W-8){1'b0}}, value})
            sb.report_mismatch($sformatf("register %0d reads %0h want %0h",
                                         reg_idx, readback, value));
    endtask

    // one search against a simulated tag whose bank holds true_len words
    task automatic run_search_session();
        int true_len;
        int flaky;
        int r;
        bit stubborn;
        true_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, sb.word_limit);
        stubborn = ($urandom_range(0, 19) == 0);
        flaky    = ($urandom_range(0, 3) == 0) ? 60 : 5;
        if (!calm)
        begin
            input_gaps   = ($urandom_range(0, 2) != 0);
            stall_bursts = ($urandom_range(0, 2) != 0);
        end
        send_item(mblp_pkg::ACT_START, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
        while (sb.searching)
        begin
            r = $urandom_range(0, 99);
            if (stubborn)
                send_item(mblp_pkg::ACT_RESPONSE, 2'($urandom_range(0, 3)),
                          ST_TRANSIENT + 3'($urandom_range(0, 3)));
            else if (r < 3)
                send_noise();
            else if (r < 5)
                send_item(mblp_pkg::ACT_STOP, 2'($urandom_range(0, 3)),
                          3'($urandom_range(0, 7)));
            else if (r < 7)
                send_item(mblp_pkg::ACT_RESPONSE, 2'($urandom_range(0, 3)),
                          (r == 5) ? mblp_pkg::ST_WRONG_PW : mblp_pkg::ST_LOCKED);
            else if (r < 9)
                send_item(mblp_pkg::ACT_START, 2'($urandom_range(0, 3)),
                          3'($urandom_range(0, 7)));
            else if (r < 9 + flaky)
                send_item(mblp_pkg::ACT_RESPONSE, 2'($urandom_range(0, 3)),
                          ST_TRANSIENT + 3'($urandom_range(0, 3)));
            else
                send_item(mblp_pkg::ACT_RESPONSE, 2'($urandom_range(0, 3)),
                          (int'(sb.probe_len) <= true_len) ? mblp_pkg::ST_OK
                                                           : mblp_pkg::ST_OVERRUN);
        end
        if ($urandom_range(0, 3) == 0)
            send_noise();
    endtask

    initial
    begin
        logic [7:0] words_setting [NUM_PHASES];
        logic [7:0] retry_setting [NUM_PHASES];
        int phase_end;

        words_setting = '{8'd64, 8'd255, 8'd1, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0};
        retry_setting = '{8'd10, 8'd255, 8'd1, 8'd0, 8'd1, 8'd255, 8'd0, 8'd0, 8'd0};
        for (int p = 6; p < NUM_PHASES; p++)
        begin
            words_setting[p] = 8'($urandom_range(0, 255));
            retry_setting[p] = 8'($urandom_range(0, 12));
        end

        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle traffic, every reply code, stop, restart, midpoint down to zero
        send_item(mblp_pkg::ACT_RESPONSE, 2'd0, mblp_pkg::ST_OK);
        send_item(mblp_pkg::ACT_STOP, 2'd0, mblp_pkg::ST_OK);
        send_item(ACT_UNUSED, 2'd3, 3'd7);
        send_item(mblp_pkg::ACT_START, 2'd3, mblp_pkg::ST_OK);
        send_item(mblp_pkg::ACT_RESPONSE, 2'd0, mblp_pkg::ST_OK);
        send_item(mblp_pkg::ACT_RESPONSE, 2'd0, mblp_pkg::ST_OVERRUN);
        for (int s = ST_TRANSIENT; s < 8; s++)
            send_item(mblp_pkg::ACT_RESPONSE, 2'd0, 3'(s));
        send_item(mblp_pkg::ACT_STOP, 2'd1, mblp_pkg::ST_LOCKED);
        send_item(mblp_pkg::ACT_START, 2'd1, mblp_pkg::ST_OK);
        send_item(mblp_pkg::ACT_RESPONSE, 2'd2, mblp_pkg::ST_WRONG_PW);
        send_item(mblp_pkg::ACT_START, 2'd2, mblp_pkg::ST_OK);
        send_item(mblp_pkg::ACT_START, 2'd0, mblp_pkg::ST_OK);
        send_item(mblp_pkg::ACT_RESPONSE, 2'd0, mblp_pkg::ST_LOCKED);
        send_item(mblp_pkg::ACT_START, 2'd2, mblp_pkg::ST_OK);
        while (sb.searching)
            send_item(mblp_pkg::ACT_RESPONSE, 2'd1, mblp_pkg::ST_OVERRUN);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p > 0)
            begin
                write_register(mblp_pkg::REG_MAX_WORDS, words_setting[p]);
                write_register(mblp_pkg::REG_MAX_RETRIES, retry_setting[p]);
            end
            if (p == NUM_PHASES - 1)
            begin
                calm         = 1'b1;
                input_gaps   = 1'b0;
                stall_bursts = 1'b0;
            end
            phase_end = (TOTAL_ITEMS * (p + 1)) / NUM_PHASES;
            while (sent < phase_end)
                run_search_session();
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
